// File: hdl/quad_visible_angle_span_macros.svh
// Assertion macros for the quad visible angle span block.
// Used by the port checker; depends on nothing else.
`ifndef QUAD_VISIBLE_ANGLE_SPAN_MACROS_SVH
`define QUAD_VISIBLE_ANGLE_SPAN_MACROS_SVH
// Check that an implication holds at every clock edge outside reset
`define QVAS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that an implication holds at every clock edge, reset included
`define QVAS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/qvas_pkg.sv
// Package for the quad visible angle span block: types and fixed constants.
// No dependencies.
`default_nettype none
package qvas_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int QUOT_BITS  = 14;
    localparam int TOL_BITS   = 8;
    localparam int NUM_CORNERS = 4;
    localparam logic [1:0] QUARTER_0 = 2'd0;
    localparam logic [1:0] QUARTER_1 = 2'd1;
    localparam logic [1:0] QUARTER_2 = 2'd2;
    localparam logic [1:0] QUARTER_3 = 2'd3;
    typedef logic [ANGLE_BITS-1:0] angle_t;
    typedef logic [TOL_BITS-1:0]   tol_t;
    // Pipeline control used at the top level: accepted-input valid and stall
    typedef struct packed {
        logic valid;
        logic stall;
    } stage_ctl_t;
endpackage
`default_nettype wire

// File: hdl/quad_visible_angle_span.sv
// Quad visible angle span: top level, pipeline control and corner lanes.
// Depends on qvas_pkg, qvas_fold, qvas_divider and qvas_span.
//
// Usage:
//   Input channel s_valid/s_ready carries a viewer point and four corners.
//   Output channel m_valid/m_ready carries angle_span, the largest shorter
//   circular difference between corner directions (65536 units per turn).
//   zero_tolerance is written through cfg_we/cfg_wdata, by the user only
//   while idle; the block itself does not enforce this. Pipeline: 1 fold
//   stage, 14 divider stages, 3 span stages, 1 output stage, the divider
//   depth set by the one quotient bit per stage of the four lane dividers.
//   Throughput: one word per cycle while m_ready is high.
//   Reset clears all valid bits and the tolerance; payload is not reset.
//   When the receiver stalls with the output full, the whole pipeline
//   holds; s_ready is low only then, so nothing is lost or repeated.
`default_nettype none
module quad_visible_angle_span #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_BITS-1:0] s_viewer_x,
    input  wire logic [COORD_BITS-1:0] s_viewer_y,
    input  wire logic [COORD_BITS-1:0] s_corner0_x,
    input  wire logic [COORD_BITS-1:0] s_corner0_y,
    input  wire logic [COORD_BITS-1:0] s_corner1_x,
    input  wire logic [COORD_BITS-1:0] s_corner1_y,
    input  wire logic [COORD_BITS-1:0] s_corner2_x,
    input  wire logic [COORD_BITS-1:0] s_corner2_y,
    input  wire logic [COORD_BITS-1:0] s_corner3_x,
    input  wire logic [COORD_BITS-1:0] s_corner3_y,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [15:0]                m_angle_span
);
    import qvas_pkg::*;
    localparam int DEPTH = 1 + QUOT_BITS + 3;
    tol_t tol_reg;
    logic [DEPTH-1:0] vld_reg;
    logic out_vld_reg;
    angle_t out_reg;
    stage_ctl_t ctl;
    logic adv;
    angle_t dir [NUM_CORNERS];
    angle_t span;
    logic [COORD_BITS-1:0] cxs [NUM_CORNERS];
    logic [COORD_BITS-1:0] cys [NUM_CORNERS];

    assign cxs = '{s_corner0_x, s_corner1_x, s_corner2_x, s_corner3_x};
    assign cys = '{s_corner0_y, s_corner1_y, s_corner2_y, s_corner3_y};

    // Stall the whole pipe only when the output word is held
    assign ctl.stall = out_vld_reg && !m_ready;
    assign ctl.valid = s_valid && s_ready;
    assign adv = !ctl.stall;
    assign s_ready = adv;

    // Corner lanes
    for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_lane
        logic [COORD_BITS:0]   num;
        logic [COORD_BITS+1:0] den;
        logic [1:0] qt;
        logic z;
        qvas_fold #(.COORD_BITS(COORD_BITS)) u_fold (
            .aclk(aclk), .adv(adv), .vx(s_viewer_x), .vy(s_viewer_y),
            .cx(cxs[i]), .cy(cys[i]), .tol(tol_reg),
            .num_reg(num), .den_reg(den), .quarter_reg(qt), .zero_reg(z)
        );
        qvas_divider #(.MAG_BITS(COORD_BITS+1)) u_div (
            .aclk(aclk), .adv(adv), .num(num), .den(den),
            .quarter_in(qt), .zero_in(z), .angle(dir[i])
        );
    end

    qvas_span u_span (
        .aclk(aclk), .adv(adv), .d0(dir[0]), .d1(dir[1]),
        .d2(dir[2]), .d3(dir[3]), .span(span)
    );

    // Advance valid bits and hold the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= '0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) tol_reg <= cfg_wdata;
            if (adv) begin
                vld_reg     <= {vld_reg[DEPTH-2:0], ctl.valid};
                out_vld_reg <= vld_reg[DEPTH-1];
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) out_reg <= span;
    end

    assign m_valid = out_vld_reg;
    assign m_angle_span = out_reg;
endmodule
`default_nettype wire

// File: hdl/qvas_divider.sv
// Pipelined restoring divider: floor((v << 14) / (u + v)) for v < u + v.
// One quotient bit per stage; depends on qvas_pkg.
`default_nettype none
module qvas_divider #(
    parameter int MAG_BITS = 25
) (
    input  wire logic                    aclk,
    input  wire logic                    adv,
    input  wire logic [MAG_BITS-1:0]     num,
    input  wire logic [MAG_BITS:0]       den,
    input  wire logic [1:0]              quarter_in,
    input  wire logic                    zero_in,
    output logic [qvas_pkg::ANGLE_BITS-1:0] angle
);
    import qvas_pkg::*;
    localparam int RB = MAG_BITS + 2;
    logic [RB-1:0]        rem_reg  [1:QUOT_BITS];
    logic [MAG_BITS:0]    den_reg  [1:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg    [1:QUOT_BITS];
    logic [1:0]           qt_reg   [1:QUOT_BITS];
    logic                 z_reg    [1:QUOT_BITS];

    // Advance one quotient bit per stage
    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
        logic [RB-1:0]        rem_k;
        logic [MAG_BITS:0]    den_k;
        logic [QUOT_BITS-1:0] q_k;
        logic [1:0]           qt_k;
        logic                 z_k;
        logic [RB-1:0] sh;
        logic [RB-1:0] diff;
        logic          ge;

        // Take the stage input from the ports or from the stage before
        if (k == 0) begin : g_first
            assign rem_k = RB'(num);
            assign den_k = den;
            assign q_k   = '0;
            assign qt_k  = quarter_in;
            assign z_k   = zero_in;
        end else begin : g_next
            assign rem_k = rem_reg[k];
            assign den_k = den_reg[k];
            assign q_k   = q_reg[k];
            assign qt_k  = qt_reg[k];
            assign z_k   = z_reg[k];
        end

        always_comb begin
            sh   = {rem_k[RB-2:0], 1'b0};
            ge   = sh >= RB'(den_k);
            diff = ge ? sh - RB'(den_k) : sh;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1] <= diff;
                den_reg[k+1] <= den_k;
                q_reg[k+1]   <= {q_k[QUOT_BITS-2:0], ge};
                qt_reg[k+1]  <= qt_k;
                z_reg[k+1]   <= z_k;
            end
        end
    end

    assign angle = z_reg[QUOT_BITS] ? '0 :
                   {qt_reg[QUOT_BITS], q_reg[QUOT_BITS]};
endmodule
`default_nettype wire

// File: hdl/qvas_fold.sv
// Corner fold stage: offset from viewer, quadrant fold and tolerance test.
// Registered output; depends on qvas_pkg.
`default_nettype none
module qvas_fold #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  adv,
    input  wire logic [COORD_BITS-1:0] vx,
    input  wire logic [COORD_BITS-1:0] vy,
    input  wire logic [COORD_BITS-1:0] cx,
    input  wire logic [COORD_BITS-1:0] cy,
    input  wire qvas_pkg::tol_t        tol,
    output logic [COORD_BITS:0]        num_reg,
    output logic [COORD_BITS+1:0]      den_reg,
    output logic [1:0]                 quarter_reg,
    output logic                       zero_reg
);
    import qvas_pkg::*;
    localparam int DB = COORD_BITS + 1;
    logic signed [DB-1:0] dx, dy;
    logic [DB-1:0] ax, ay, u_next, v_next;
    logic [1:0] q_next;
    logic z_next;

    // Fold the offset into the first quadrant
    always_comb begin
        dx = DB'(signed'(cx)) - DB'(signed'(vx));
        dy = DB'(signed'(cy)) - DB'(signed'(vy));
        ax = dx[DB-1] ? DB'(-dx) : DB'(dx);
        ay = dy[DB-1] ? DB'(-dy) : DB'(dy);
        z_next = (ax <= DB'(tol)) && (ay <= DB'(tol));
        if (dx <= 0 && dy > 0) begin
            u_next = ay; v_next = ax; q_next = QUARTER_0;
        end else if (dy <= 0 && dx < 0) begin
            u_next = ax; v_next = ay; q_next = QUARTER_1;
        end else if (dx >= 0 && dy < 0) begin
            u_next = ay; v_next = ax; q_next = QUARTER_2;
        end else begin
            u_next = ax; v_next = ay; q_next = QUARTER_3;
        end
        if (dx == 0 && dy == 0) z_next = 1'b1;
    end

    // Hold folded values for the divider
    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg     <= v_next;
            den_reg     <= {1'b0, u_next} + {1'b0, v_next};
            quarter_reg <= q_next;
            zero_reg    <= z_next;
        end
    end
endmodule
`default_nettype wire

// File: hdl/qvas_span.sv
// Span stage: six circular differences, then a registered max tree.
// Depends on qvas_pkg.
`default_nettype none
module qvas_span (
    input  wire logic           aclk,
    input  wire logic           adv,
    input  wire qvas_pkg::angle_t d0,
    input  wire qvas_pkg::angle_t d1,
    input  wire qvas_pkg::angle_t d2,
    input  wire qvas_pkg::angle_t d3,
    output qvas_pkg::angle_t    span
);
    import qvas_pkg::*;
    angle_t diff_reg [6];
    angle_t m_reg [2];
    angle_t span_reg;
    angle_t dir [4];
    assign dir = '{d0, d1, d2, d3};

    function automatic angle_t circ(input angle_t a, input angle_t b);
        angle_t cw, acw;
        cw  = a - b;
        acw = b - a;
        return (cw < acw) ? cw : acw;
    endfunction

    // Form pair differences, then reduce
    always_ff @(posedge aclk) begin
        if (adv) begin
            diff_reg[0] <= circ(dir[1], dir[0]);
            diff_reg[1] <= circ(dir[2], dir[0]);
            diff_reg[2] <= circ(dir[3], dir[0]);
            diff_reg[3] <= circ(dir[2], dir[1]);
            diff_reg[4] <= circ(dir[3], dir[1]);
            diff_reg[5] <= circ(dir[3], dir[2]);
            m_reg[0] <= (diff_reg[0] > diff_reg[1]) ?
                (diff_reg[0] > diff_reg[2] ? diff_reg[0] : diff_reg[2]) :
                (diff_reg[1] > diff_reg[2] ? diff_reg[1] : diff_reg[2]);
            m_reg[1] <= (diff_reg[3] > diff_reg[4]) ?
                (diff_reg[3] > diff_reg[5] ? diff_reg[3] : diff_reg[5]) :
                (diff_reg[4] > diff_reg[5] ? diff_reg[4] : diff_reg[5]);
            span_reg <= (m_reg[0] > m_reg[1]) ? m_reg[0] : m_reg[1];
        end
    end
    assign span = span_reg;
endmodule
`default_nettype wire

// File: hdl/qvas_checker.sv
// Port checker for quad_visible_angle_span, bound to the top level.
// Depends on quad_visible_angle_span_macros.svh.
`default_nettype none
`include "quad_visible_angle_span_macros.svh"
module qvas_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_angle_span
);
    `QVAS_ASSERT(a_span_range, aclk, aresetn, m_valid |-> m_angle_span <= 16'd32768, "span range")
    `QVAS_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid && $stable(m_angle_span), "held word changed")
    `QVAS_ASSERT(a_ready, aclk, aresetn, (!m_valid || m_ready) |-> s_ready, "input blocked needlessly")
    `QVAS_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "valid after reset")
endmodule
bind quad_visible_angle_span qvas_port_checker u_qvas_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_angle_span(m_angle_span)
);
`default_nettype wire
